/* design/sio_pkg.sv */
// Package for the socket packet header parser: payload structs, phase codes,
// packet type codes and limits. No dependencies.
`timescale 1ns / 1ps
package sio_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam int unsigned PosW = 17;
    localparam logic [63:0] ACK_LIMIT = 64'd1844674407370955161;
    localparam logic [2:0] NO_SOCKET = 3'd7;

    localparam logic [2:0] ENGINE_MESSAGE = 3'd4;

    localparam logic [2:0] SOCK_CONNECT       = 3'd0;
    localparam logic [2:0] SOCK_DISCONNECT    = 3'd1;
    localparam logic [2:0] SOCK_EVENT         = 3'd2;
    localparam logic [2:0] SOCK_ACK           = 3'd3;
    localparam logic [2:0] SOCK_CONNECT_ERROR = 3'd4;

    typedef enum logic [3:0] {
        PH_ENGINE = 4'd0,
        PH_OPAQUE = 4'd1,
        PH_SOCKET = 4'd2,
        PH_FIELD  = 4'd3,
        PH_NS     = 4'd4,
        PH_ACK    = 4'd5,
        PH_TAIL   = 4'd6,
        PH_WS1    = 4'd7,
        PH_STR    = 4'd8,
        PH_ESC    = 4'd9,
        PH_HEX    = 4'd10,
        PH_WS2    = 4'd11,
        PH_DONE   = 4'd12
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        packet_valid;
        logic [2:0]  engine_type;
        logic [2:0]  socket_type;
        logic        has_namespace;
        logic [15:0] namespace_length;
        logic        has_ack;
        logic [63:0] ack_number;
        logic [15:0] json_offset;
        logic [15:0] json_length;
        logic [15:0] name_offset;
        logic [15:0] name_length;
        logic        packet_too_long;
    } out_item_t;

endpackage

/* design/socketio_packet_header_parser_unit.sv */
// Top level of the socket packet header parser: per-byte state machine and
// result register. Depends on sio_pkg.
`timescale 1ns / 1ps
// One packet byte is accepted per item, one per clock cycle when the output
// side does not stall. Each byte updates the parse state through one short
// path (a phase decode and a multiply-by-ten add on the ack id); on the last
// byte the result item is loaded into a single output register and shows in
// the next cycle. Input stalls, for any byte, while that register holds an
// item and the output side stalls. No result comes for other bytes.
module socketio_packet_header_parser_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sio_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sio_pkg::out_item_t out_data
);

    sio_pkg::phase_t phase_reg, phase_next;
    logic [sio_pkg::PosW-1:0] pos_reg, pos_next;
    logic [63:0] ack_reg, ack_next;
    logic        ack_seen_reg, ack_seen_next;
    logic        ns_seen_reg, ns_seen_next;
    logic [15:0] ns_count_reg, ns_count_next;
    logic [15:0] json_start_reg, json_start_next;
    logic [15:0] name_start_reg, name_start_next;
    logic [15:0] name_count_reg, name_count_next;
    logic [2:0]  hex_left_reg, hex_left_next;
    logic [7:0]  first_json_reg, first_json_next;
    logic [2:0]  engine_reg, engine_next;
    logic [2:0]  socket_reg, socket_next;
    logic        err_reg, err_next;

    logic               out_valid_reg;
    sio_pkg::out_item_t out_data_reg, result;

    logic       accept;
    logic [7:0] b;
    logic [3:0] d;
    logic [15:0] pos16;
    logic        is_dig, is_blank, is_hex;
    logic        too_long, valid;
    logic [15:0] len, joff, jlen;
    logic        empty;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign b        = in_data.data_byte;
    assign d        = b[3:0] - 4'd0;
    assign pos16    = pos_reg[15:0];
    assign is_dig   = (b >= "0") && (b <= "9");
    assign is_blank = (b == " ") || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
    assign is_hex   = is_dig || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        ack_next        = ack_reg;
        ack_seen_next   = ack_seen_reg;
        ns_seen_next    = ns_seen_reg;
        ns_count_next   = ns_count_reg;
        json_start_next = json_start_reg;
        name_start_next = name_start_reg;
        name_count_next = name_count_reg;
        hex_left_next   = hex_left_reg;
        first_json_next = first_json_reg;
        engine_next     = engine_reg;
        socket_next     = socket_reg;
        err_next        = err_reg;

        if (pos_reg >= sio_pkg::PosW'(sio_pkg::MAX_PACKET_BYTES)) begin
            pos_next = sio_pkg::PosW'(sio_pkg::MAX_PACKET_BYTES + 1);
        end
        else begin
            pos_next = pos_reg + 1'b1;
            if (!err_reg) begin
                unique case (phase_reg)
                    sio_pkg::PH_ENGINE:
                    begin
                        if (b < "0" || b > "6") err_next = 1'b1;
                        else begin
                            engine_next = d[2:0];
                            phase_next  = (d[2:0] == sio_pkg::ENGINE_MESSAGE)
                                          ? sio_pkg::PH_SOCKET : sio_pkg::PH_OPAQUE;
                        end
                    end
                    sio_pkg::PH_SOCKET:
                    begin
                        if (b < "0" || b > "4") err_next = 1'b1;
                        else begin
                            socket_next = d[2:0];
                            phase_next  = sio_pkg::PH_FIELD;
                        end
                    end
                    sio_pkg::PH_NS:
                    begin
                        if (b == ",") phase_next = sio_pkg::PH_ACK;
                        else if (b < 8'h21 || b == 8'h7f) err_next = 1'b1;
                        else ns_count_next = ns_count_reg + 16'd1;
                    end
                    sio_pkg::PH_FIELD, sio_pkg::PH_ACK:
                    begin
                        // a field byte that is not '/' is handled as in the ack phase
                        if (phase_reg == sio_pkg::PH_FIELD && b == "/") begin
                            ns_seen_next  = 1'b1;
                            ns_count_next = 16'd1;
                            phase_next    = sio_pkg::PH_NS;
                        end
                        else if (is_dig) begin
                            phase_next = sio_pkg::PH_ACK;
                            if (ack_reg > sio_pkg::ACK_LIMIT ||
                                (ack_reg == sio_pkg::ACK_LIMIT && d > 4'd5))
                                err_next = 1'b1;
                            else begin
                                ack_seen_next = 1'b1;
                                ack_next = (ack_reg << 3) + (ack_reg << 1) + 64'(d);
                            end
                        end
                        else begin
                            phase_next      = sio_pkg::PH_ACK;
                            json_start_next = pos16;
                            first_json_next = b;
                            if (socket_reg == sio_pkg::SOCK_EVENT) begin
                                if (b == "[") phase_next = sio_pkg::PH_WS1;
                                else err_next = 1'b1;
                            end
                            else phase_next = sio_pkg::PH_TAIL;
                        end
                    end
                    sio_pkg::PH_WS1:
                    begin
                        if (!is_blank) begin
                            if (b != "\"") err_next = 1'b1;
                            else begin
                                name_start_next = pos16 + 16'd1;
                                name_count_next = 16'd0;
                                phase_next      = sio_pkg::PH_STR;
                            end
                        end
                    end
                    sio_pkg::PH_STR:
                    begin
                        if (b == "\"") phase_next = sio_pkg::PH_WS2;
                        else if (b < 8'h20) err_next = 1'b1;
                        else begin
                            name_count_next = name_count_reg + 16'd1;
                            if (b == "\\") phase_next = sio_pkg::PH_ESC;
                        end
                    end
                    sio_pkg::PH_ESC:
                    begin
                        name_count_next = name_count_reg + 16'd1;
                        if (b == "u") begin
                            hex_left_next = 3'd4;
                            phase_next    = sio_pkg::PH_HEX;
                        end
                        else if (b == "\"" || b == "\\" || b == "/" || b == "b" ||
                                 b == "f" || b == "n" || b == "r" || b == "t")
                            phase_next = sio_pkg::PH_STR;
                        else err_next = 1'b1;
                    end
                    sio_pkg::PH_HEX:
                    begin
                        name_count_next = name_count_reg + 16'd1;
                        if (!is_hex) err_next = 1'b1;
                        else begin
                            hex_left_next = hex_left_reg - 3'd1;
                            if (hex_left_reg == 3'd1) phase_next = sio_pkg::PH_STR;
                        end
                    end
                    sio_pkg::PH_WS2:
                    begin
                        if (!is_blank) begin
                            if (b == "," || b == "]") phase_next = sio_pkg::PH_DONE;
                            else err_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result on the last byte, built from the updated state.
    always_comb
    begin
        too_long = pos_next > sio_pkg::PosW'(sio_pkg::MAX_PACKET_BYTES);
        len      = pos_next[15:0];
        empty    = (phase_next == sio_pkg::PH_FIELD) || (phase_next == sio_pkg::PH_ACK);
        joff     = empty ? len : json_start_next;
        jlen     = len - joff;
        valid    = 1'b0;
        result   = '0;
        if (!too_long && !err_next && phase_next != sio_pkg::PH_OPAQUE &&
            phase_next != sio_pkg::PH_ENGINE && phase_next != sio_pkg::PH_SOCKET &&
            phase_next != sio_pkg::PH_NS) begin
            unique case (socket_next)
                sio_pkg::SOCK_CONNECT:
                    valid = !ack_seen_next && (jlen == 16'd0 || first_json_next == "{");
                sio_pkg::SOCK_DISCONNECT:
                    valid = !ack_seen_next && jlen == 16'd0;
                sio_pkg::SOCK_EVENT:
                    valid = phase_next == sio_pkg::PH_DONE;
                sio_pkg::SOCK_ACK:
                    valid = ack_seen_next && jlen >= 16'd2 && first_json_next == "["
                            && b == "]";
                sio_pkg::SOCK_CONNECT_ERROR:
                    valid = !ack_seen_next && jlen >= 16'd2 && first_json_next == "{"
                            && b == "}";
                default: valid = 1'b0;
            endcase
        end
        if (!too_long && !err_next && phase_next == sio_pkg::PH_OPAQUE) begin
            result.packet_valid = 1'b1;
            result.engine_type  = engine_next;
            result.socket_type  = sio_pkg::NO_SOCKET;
        end
        else if (valid) begin
            result.packet_valid     = 1'b1;
            result.engine_type      = engine_next;
            result.socket_type      = socket_next;
            result.has_namespace    = ns_seen_next;
            result.namespace_length = ns_count_next;
            result.has_ack          = ack_seen_next;
            result.ack_number       = ack_next;
            result.json_offset      = joff;
            result.json_length      = jlen;
            if (socket_next == sio_pkg::SOCK_EVENT) begin
                result.name_offset = name_start_next;
                result.name_length = name_count_next;
            end
        end
        result.packet_too_long = too_long;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= sio_pkg::PH_ENGINE;
            pos_reg        <= '0;
            ack_reg        <= '0;
            ack_seen_reg   <= 1'b0;
            ns_seen_reg    <= 1'b0;
            ns_count_reg   <= '0;
            json_start_reg <= '0;
            name_start_reg <= '0;
            name_count_reg <= '0;
            hex_left_reg   <= '0;
            first_json_reg <= '0;
            engine_reg     <= '0;
            socket_reg     <= sio_pkg::NO_SOCKET;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (accept && in_data.last_byte) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
            if (accept) begin
                if (in_data.last_byte) begin
                    // restart for the next packet
                    phase_reg      <= sio_pkg::PH_ENGINE;
                    pos_reg        <= '0;
                    ack_reg        <= '0;
                    ack_seen_reg   <= 1'b0;
                    ns_seen_reg    <= 1'b0;
                    ns_count_reg   <= '0;
                    json_start_reg <= '0;
                    name_start_reg <= '0;
                    name_count_reg <= '0;
                    hex_left_reg   <= '0;
                    first_json_reg <= '0;
                    engine_reg     <= '0;
                    socket_reg     <= sio_pkg::NO_SOCKET;
                    err_reg        <= 1'b0;
                end
                else begin
                    phase_reg      <= phase_next;
                    pos_reg        <= pos_next;
                    ack_reg        <= ack_next;
                    ack_seen_reg   <= ack_seen_next;
                    ns_seen_reg    <= ns_seen_next;
                    ns_count_reg   <= ns_count_next;
                    json_start_reg <= json_start_next;
                    name_start_reg <= name_start_next;
                    name_count_reg <= name_count_next;
                    hex_left_reg   <= hex_left_next;
                    first_json_reg <= first_json_next;
                    engine_reg     <= engine_next;
                    socket_reg     <= socket_next;
                    err_reg        <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.last_byte) out_data_reg <= result;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.packet_valid |-> out_data.ack_number == 64'd0)
        else $error("invalid packet carries fields");
    a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= sio_pkg::PosW'(sio_pkg::MAX_PACKET_BYTES + 1))
        else $error("byte position past cap");
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_byte |=> out_valid && phase_reg == sio_pkg::PH_ENGINE)
        else $error("last byte gave no result");
`endif

endmodule
